### sv/assert_macros.svh
// Assertion helpers, included by lcs_length_engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold on every clock edge out of reset.
`define CHK_ALWAYS(label, ck, rs, expr, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (expr)) else $error(msg);

// Same-cycle implication.
`define CHK_IMPL(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define CHK_NEXT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

### sv/lcs_pkg.sv
package lcs_pkg;

  // Default capacity of the reference store
  localparam int MAX_Y_LEN_DEF = 64;

  // Width of the reported length and its saturation value
  localparam int LEN_W   = 7;
  localparam int LEN_MAX = 127;

  localparam int SYM_W = 8;

  // Input item action codes; the last code is unused and ignored
  typedef enum logic [1:0] {
    ACT_LOAD   = 2'd0,
    ACT_STEP   = 2'd1,
    ACT_FINISH = 2'd2,
    ACT_UNUSED = 2'd3
  } act_t;

  // Control part of the token that travels down the cell chain
  typedef struct packed {
    logic             vld;
    act_t             op;
    logic [SYM_W-1:0] sym;
  } tok_ctl_t;

endpackage

### sv/lcs_cell.sv
// One reference position: holds its byte and its score, and passes the
// token (action, stream byte, diagonal and left scores) to the next cell.
module lcs_cell #(
  parameter int MAX_Y_LEN = lcs_pkg::MAX_Y_LEN_DEF,
  parameter int IDX       = 0,
  localparam int SW = $clog2(MAX_Y_LEN + 1),
  localparam int CW = $clog2(MAX_Y_LEN + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [CW-1:0]      ref_count,
  input  lcs_pkg::tok_ctl_t  ctl_in,
  input  logic [SW-1:0]      diag_in,
  input  logic [SW-1:0]      left_in,
  output lcs_pkg::tok_ctl_t  ctl_out,
  output logic [SW-1:0]      diag_out,
  output logic [SW-1:0]      left_out
);

  logic [lcs_pkg::SYM_W-1:0] ref_byte;
  logic [SW-1:0]             score;
  logic [SW-1:0]             nv;
  logic                      active;
  logic                      capture;
  logic                      upd;

  // Position holds a loaded byte; a load lands in the first free position
  assign active  = ref_count > CW'(IDX);
  assign capture = ctl_in.vld && (ctl_in.op == lcs_pkg::ACT_LOAD) &&
                   (ref_count == CW'(IDX));
  assign upd     = ctl_in.vld && (ctl_in.op == lcs_pkg::ACT_STEP) && active;

  // Recurrence: match takes diagonal plus one, else max of up and left
  always_comb begin
    if (ref_byte == ctl_in.sym) begin
      nv = diag_in + SW'(1);
    end else if (score >= left_in) begin
      nv = score;
    end else begin
      nv = left_in;
    end
  end

  // Stored byte and score
  always_ff @(posedge clk) begin
    if (capture) begin
      ref_byte <= ctl_in.sym;
      score    <= left_in;
    end else if (upd) begin
      score <= nv;
    end
  end

  // Token hand-off to the neighbour; only the valid bit is reset
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.vld <= 1'b0;
    end else begin
      ctl_out.vld <= ctl_in.vld;
    end
    ctl_out.op  <= ctl_in.op;
    ctl_out.sym <= ctl_in.sym;
    if (active) begin
      diag_out <= score;
      left_out <= upd ? nv : score;
    end else begin
      diag_out <= diag_in;
      left_out <= left_in;
    end
  end

endmodule

### sv/lcs_length_engine.sv
// LCS length engine. Load a reference string one byte per item (action 0),
// stream the other string one byte per item (action 1), then send a finish
// item (action 2) to get the length of the longest common subsequence and an
// overflow flag, after which the engine is empty again. The reference is held
// in a chain of MAX_Y_LEN cells, one per position; every item is sent down
// the chain as a token moving one cell per clock, so each item occupies the
// engine until its token leaves the last cell, and one item is in work at a
// time. Reference bytes past MAX_Y_LEN are dropped and set the overflow flag;
// lengths above 127 saturate. Action 3 is accepted and ignored at once.
// A finish item is taken only when the result register is free or being read.
`include "assert_macros.svh"

module lcs_length_engine #(
  parameter int MAX_Y_LEN = lcs_pkg::MAX_Y_LEN_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 action,
  input  logic [lcs_pkg::SYM_W-1:0]  symbol,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [lcs_pkg::LEN_W-1:0]  lcs_length,
  output logic                       ref_overflow
);

  localparam int SW = $clog2(MAX_Y_LEN + 1);
  localparam int CW = $clog2(MAX_Y_LEN + 1);
  localparam int XW = (SW > lcs_pkg::LEN_W) ? SW : lcs_pkg::LEN_W;

  lcs_pkg::tok_ctl_t ctl  [MAX_Y_LEN+1];
  logic [SW-1:0]     diag [MAX_Y_LEN+1];
  logic [SW-1:0]     left [MAX_Y_LEN+1];

  logic          busy;
  logic [CW-1:0] ref_count;
  logic          overflow_flag;
  logic          accept;
  logic          fin_exit;
  logic [XW-1:0] fin_x;

  // Input handshake; a finish needs the result register free or being read
  assign in_ready = !busy &&
                    ((action != lcs_pkg::ACT_FINISH) || !out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  // Token into the first cell; unused action sends nothing
  always_comb begin
    ctl[0].vld = accept && (action != lcs_pkg::ACT_UNUSED);
    ctl[0].op  = lcs_pkg::act_t'(action);
    ctl[0].sym = symbol;
    diag[0]    = '0;
    left[0]    = '0;
  end

  // Cell chain
  for (genvar j = 0; j < MAX_Y_LEN; j++) begin : g_cell
    lcs_cell #(
      .MAX_Y_LEN (MAX_Y_LEN),
      .IDX       (j)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ref_count (ref_count),
      .ctl_in    (ctl[j]),
      .diag_in   (diag[j]),
      .left_in   (left[j]),
      .ctl_out   (ctl[j+1]),
      .diag_out  (diag[j+1]),
      .left_out  (left[j+1])
    );
  end

  assign fin_exit = ctl[MAX_Y_LEN].vld && (ctl[MAX_Y_LEN].op == lcs_pkg::ACT_FINISH);
  assign fin_x    = XW'(left[MAX_Y_LEN]);

  // Busy from a token entering the chain until it leaves; commit at exit
  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      ref_count     <= '0;
      overflow_flag <= 1'b0;
    end else begin
      if (ctl[0].vld) begin
        busy <= 1'b1;
      end else if (ctl[MAX_Y_LEN].vld) begin
        busy <= 1'b0;
      end
      if (ctl[MAX_Y_LEN].vld) begin
        unique case (ctl[MAX_Y_LEN].op)
          lcs_pkg::ACT_LOAD: begin
            if (ref_count == CW'(MAX_Y_LEN)) begin
              overflow_flag <= 1'b1;
            end else begin
              ref_count <= ref_count + CW'(1);
            end
          end
          lcs_pkg::ACT_FINISH: begin
            ref_count     <= '0;
            overflow_flag <= 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_exit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_exit) begin
      lcs_length   <= (fin_x > XW'(lcs_pkg::LEN_MAX)) ?
                      lcs_pkg::LEN_W'(lcs_pkg::LEN_MAX) : fin_x[lcs_pkg::LEN_W-1:0];
      ref_overflow <= overflow_flag;
    end
  end

  // Checks
  `CHK_ALWAYS(a_count_range, clk, rst, ref_count <= CW'(MAX_Y_LEN), "ref_count past capacity")
  `CHK_IMPL(a_exit_busy, clk, rst, ctl[MAX_Y_LEN].vld, busy, "token left chain while idle")
  `CHK_IMPL(a_fin_free, clk, rst, fin_exit, !out_valid || out_ready, "result register overrun")
  `CHK_IMPL(a_out_src, clk, rst, $rose(out_valid), $past(fin_exit), "result without finish")

endmodule
